>>> rtl/ffch_pkg.sv
// ============================================================================
// ffch_pkg - shared types and constants of the first-fit heap allocator
// Field widths, status codes, opcodes and the packed word layouts.
// ============================================================================
package ffch_pkg;

    localparam int POOLS_DEF     = 3;
    localparam int MAX_GRAN_DEF  = 8192;
    localparam int ALIGN_DEF     = 8;

    localparam int CFG_REGS      = 3;
    localparam int CFG_W         = 14;
    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8192);

    localparam int POOL_W        = 2;
    localparam int REQ_W         = 24;
    localparam int OFF_W         = 16;
    localparam int FREE_W        = 17;

    localparam logic OP_ALLOC    = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_BAD_POOL = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    // input word, first field in the highest bits
    typedef struct packed {
        logic [OFF_W-1:0]  payload_offset;
        logic [REQ_W-1:0]  request_bytes;
        logic [POOL_W-1:0] pool;
        logic              opcode;
    } t_req;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [FREE_W-1:0] min_free_bytes;
        logic [FREE_W-1:0] free_bytes;
        logic [OFF_W-1:0]  granted_offset;
        t_status           status;
    } t_res;

    localparam int REQ_BITS   = $bits(t_req);
    localparam int RES_BITS   = $bits(t_res);
    localparam int S_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

endpackage

>>> rtl/ffch_ram.sv
// ============================================================================
// ffch_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module ffch_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 24576,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ffch_core.sv
// ============================================================================
// ffch_core - allocator sequencer
// Walks the address-ordered free list one header read at a time, splits,
// unlinks and reinserts blocks with merging, and keeps per-pool counters.
// ============================================================================
module ffch_core import ffch_pkg::*; #(
    parameter int  POOLS             = POOLS_DEF,
    parameter int  MAX_POOL_GRANULES = MAX_GRAN_DEF,
    parameter int  ALIGN_BYTES       = ALIGN_DEF,
    localparam int GW  = $clog2(MAX_POOL_GRANULES),
    localparam int HW  = 2 * GW + 2,
    localparam int AW  = $clog2(POOLS * (1 << GW))
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_ready,
    input  t_req                        i_req,
    input  logic [POOLS-1:0][CFG_W-1:0] i_cfg_gran,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output t_res                        o_res,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [HW-1:0]               o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [HW-1:0]               i_mem_rdata
);

    localparam int ASH   = $clog2(ALIGN_BYTES);
    localparam int FCW   = GW + ASH;
    localparam int PW    = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int WANTW = REQ_W + 2 - ASH;
    localparam int HOW   = OFF_W - ASH;
    localparam int GCW   = (GW + 1 > CFG_W) ? GW + 1 : CFG_W;

    typedef struct packed {
        logic [GW-1:0] size;
        logic          alloc;
        logic          nv;
        logic [GW-1:0] next;
    } t_hdr;

    typedef enum logic [4:0] {
        S_IDLE, S_SETUP0, S_SETUP1, S_DISPATCH,
        S_A_CHK, S_A_UNLINK, S_A_SPLIT, S_A_FIN,
        S_F_CHK,
        S_I_WALK, S_I_WAIT, S_I_MERGE, S_I_ADJ, S_I_NWAIT, S_I_WR, S_I_LINK,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] maddr(input logic [PW-1:0] p, input logic [GW-1:0] g);
        maddr = AW'({p, g});
    endfunction

    t_state          r_state;
    logic [PW-1:0]   r_p;
    logic            r_bad;
    logic            r_op;
    logic [REQ_W-1:0] r_req;
    logic [OFF_W-1:0] r_off;
    t_status         r_status;
    logic [OFF_W-1:0] r_grant;
    logic [WANTW-1:0] r_want;
    logic [GW-1:0]   r_e;

    // alloc walk
    logic [GW-1:0]   r_blk;
    logic [GW-1:0]   r_prev;
    logic            r_prev_head;
    t_hdr            r_phdr;
    t_hdr            r_cur;
    logic [GW-1:0]   r_fsize;

    // reinsert
    logic [GW-1:0]   r_b;
    t_hdr            r_bh;
    logic [GW-1:0]   r_it;
    t_hdr            r_ih;
    logic            r_at_head;
    logic [GW-1:0]   r_nxt;
    logic            r_ret_alloc;

    // pool state
    logic [GW-1:0]   r_head  [POOLS];
    logic [GW-1:0]   r_end   [POOLS];
    logic [FCW-1:0]  r_fc    [POOLS];
    logic [FCW-1:0]  r_min   [POOLS];
    logic            r_ready [POOLS];

    t_hdr              rd;
    logic [GW-1:0]     cur_head, cur_end;
    logic [FCW-1:0]    cur_fc;
    logic [GCW-1:0]    g_c;
    logic [GW-1:0]     e_c;
    logic [REQ_W-ASH:0] ceil_g;
    logic [WANTW-1:0]  want_c;
    logic [WANTW+ASH-1:0] want_bytes;
    logic              alloc_bad;
    logic [HOW-1:0]    h_c;
    logic              free_bad;
    logic              walk_on;
    logic [GW-1:0]     rem_c, nb_c;
    logic              w_valid, w_stop;
    logic [GW-1:0]     w_nxt;
    logic              merge_c, adj_c;
    logic [FCW-1:0]    n_fc;

    assign rd       = t_hdr'(i_mem_rdata);
    assign cur_head = r_head[r_p];
    assign cur_end  = r_end[r_p];
    assign cur_fc   = r_fc[r_p];

    // pool size clamp at setup
    always_comb begin
        g_c = GCW'(i_cfg_gran[r_p]);
        if (g_c < GCW'(4)) begin
            g_c = GCW'(4);
        end else if (g_c > GCW'(MAX_POOL_GRANULES)) begin
            g_c = GCW'(MAX_POOL_GRANULES);
        end
        e_c = GW'(g_c - GCW'(1));
    end

    assign ceil_g     = (REQ_W+1-ASH)'(((REQ_W+1)'(r_req) + (REQ_W+1)'(ALIGN_BYTES-1)) >> ASH);
    assign want_c     = {1'b0, ceil_g} + WANTW'(1);
    assign want_bytes = {want_c, {ASH{1'b0}}};
    assign alloc_bad  = (r_req == '0) || (want_bytes > (WANTW+ASH)'(cur_fc));

    assign h_c      = r_off[OFF_W-1:ASH] - HOW'(1);
    assign free_bad = (r_off == '0) || (r_off[ASH-1:0] != '0) || (h_c >= cur_end);

    assign walk_on  = (rd.size < r_want) && rd.nv;
    assign rem_c    = r_cur.size - GW'(r_want);
    assign nb_c     = r_blk + GW'(r_want);

    assign w_valid  = r_at_head | r_ih.nv;
    assign w_nxt    = r_at_head ? cur_head : r_ih.next;
    assign w_stop   = !w_valid || (w_nxt >= r_b);
    assign merge_c  = !r_at_head && (({1'b0, r_it} + {1'b0, r_ih.size}) == {1'b0, r_b});
    assign adj_c    = ({1'b0, r_b} + {1'b0, r_bh.size}) == {1'b0, r_nxt};

    assign n_fc     = cur_fc - {r_fsize, {ASH{1'b0}}};

    // header memory ports
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        unique case (r_state)
            S_SETUP0: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, '0);
                o_mem_wdata = HW'(t_hdr'{size: e_c, alloc: 1'b0, nv: 1'b1, next: e_c});
            end
            S_SETUP1: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, r_e);
            end
            S_DISPATCH: begin
                if (r_op == OP_ALLOC && !alloc_bad) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = maddr(r_p, cur_head);
                end else if (r_op == OP_FREE && !free_bad) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = maddr(r_p, GW'(h_c));
                end
            end
            S_A_CHK: begin
                if (walk_on) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = maddr(r_p, rd.next);
                end
            end
            S_A_UNLINK: begin
                if (!r_prev_head) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = maddr(r_p, r_prev);
                    o_mem_wdata = HW'(t_hdr'{size: r_phdr.size, alloc: r_phdr.alloc,
                                             nv: r_cur.nv, next: r_cur.next});
                end
            end
            S_A_SPLIT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, nb_c);
                o_mem_wdata = HW'(t_hdr'{size: rem_c, alloc: 1'b0, nv: 1'b0, next: '0});
            end
            S_A_FIN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, r_blk);
                o_mem_wdata = HW'(t_hdr'{size: r_fsize, alloc: 1'b1, nv: 1'b0, next: '0});
            end
            S_F_CHK: begin
                if (rd.alloc && !rd.nv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = maddr(r_p, r_b);
                    o_mem_wdata = HW'(t_hdr'{size: rd.size, alloc: 1'b0, nv: rd.nv,
                                             next: rd.next});
                end
            end
            S_I_WALK: begin
                if (!w_stop) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = maddr(r_p, w_nxt);
                end
            end
            S_I_ADJ: begin
                if (adj_c && r_nxt != cur_end) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = maddr(r_p, r_nxt);
                end
            end
            S_I_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, r_b);
                o_mem_wdata = HW'(r_bh);
            end
            S_I_LINK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = maddr(r_p, r_it);
                o_mem_wdata = HW'(t_hdr'{size: r_ih.size, alloc: r_ih.alloc,
                                         nv: 1'b1, next: r_b});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < POOLS; i++) begin
                r_head[i]  <= '0;
                r_end[i]   <= '0;
                r_fc[i]    <= '0;
                r_min[i]   <= '0;
                r_ready[i] <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_p      <= i_req.pool[PW-1:0];
                        r_op     <= i_req.opcode;
                        r_req    <= i_req.request_bytes;
                        r_off    <= i_req.payload_offset;
                        r_grant  <= '0;
                        r_status <= ST_FAIL;
                        if (i_req.pool >= POOL_W'(POOLS)) begin
                            r_bad    <= 1'b1;
                            r_status <= ST_BAD_POOL;
                            r_state  <= S_DONE;
                        end else if (!r_ready[i_req.pool[PW-1:0]]) begin
                            r_bad   <= 1'b0;
                            r_state <= S_SETUP0;
                        end else begin
                            r_bad   <= 1'b0;
                            r_state <= S_DISPATCH;
                        end
                    end
                end
                S_SETUP0: begin
                    r_e     <= e_c;
                    r_state <= S_SETUP1;
                end
                S_SETUP1: begin
                    r_head[r_p]  <= '0;
                    r_end[r_p]   <= r_e;
                    r_fc[r_p]    <= {r_e, {ASH{1'b0}}};
                    r_min[r_p]   <= {r_e, {ASH{1'b0}}};
                    r_ready[r_p] <= 1'b1;
                    r_state      <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_want <= want_c;
                    if (r_op == OP_ALLOC) begin
                        if (alloc_bad) begin
                            r_status <= ST_FAIL;
                            r_state  <= S_DONE;
                        end else begin
                            r_blk       <= cur_head;
                            r_prev_head <= 1'b1;
                            r_state     <= S_A_CHK;
                        end
                    end else begin
                        if (free_bad) begin
                            r_status <= ST_IGNORED;
                            r_state  <= S_DONE;
                        end else begin
                            r_b     <= GW'(h_c);
                            r_state <= S_F_CHK;
                        end
                    end
                end
                S_A_CHK: begin
                    if (walk_on) begin
                        r_prev      <= r_blk;
                        r_phdr      <= rd;
                        r_prev_head <= 1'b0;
                        r_blk       <= rd.next;
                    end else if (r_blk == cur_end || rd.size < r_want) begin
                        r_status <= ST_FAIL;
                        r_state  <= S_DONE;
                    end else begin
                        r_cur   <= rd;
                        r_state <= S_A_UNLINK;
                    end
                end
                S_A_UNLINK: begin
                    if (r_prev_head) begin
                        r_head[r_p] <= r_cur.next;
                    end
                    if (rem_c > GW'(2)) begin
                        r_state <= S_A_SPLIT;
                    end else begin
                        r_fsize <= r_cur.size;
                        r_state <= S_A_FIN;
                    end
                end
                S_A_SPLIT: begin
                    r_fsize     <= GW'(r_want);
                    r_b         <= nb_c;
                    r_bh        <= '{size: rem_c, alloc: 1'b0, nv: 1'b0, next: '0};
                    r_at_head   <= 1'b1;
                    r_it        <= '0;
                    r_ret_alloc <= 1'b1;
                    r_state     <= S_I_WALK;
                end
                S_A_FIN: begin
                    r_fc[r_p] <= n_fc;
                    if (n_fc < r_min[r_p]) begin
                        r_min[r_p] <= n_fc;
                    end
                    r_status <= ST_OK;
                    r_grant  <= OFF_W'({({1'b0, r_blk} + (GW+1)'(1)), {ASH{1'b0}}});
                    r_state  <= S_DONE;
                end
                S_F_CHK: begin
                    if (!rd.alloc || rd.nv) begin
                        r_status <= ST_IGNORED;
                        r_state  <= S_DONE;
                    end else begin
                        r_fc[r_p]   <= cur_fc + {rd.size, {ASH{1'b0}}};
                        r_bh        <= '{size: rd.size, alloc: 1'b0, nv: rd.nv, next: rd.next};
                        r_at_head   <= 1'b1;
                        r_it        <= '0;
                        r_ret_alloc <= 1'b0;
                        r_status    <= ST_OK;
                        r_state     <= S_I_WALK;
                    end
                end
                S_I_WALK: begin
                    r_nxt <= w_nxt;
                    if (w_stop) begin
                        r_state <= S_I_MERGE;
                    end else begin
                        r_it      <= w_nxt;
                        r_at_head <= 1'b0;
                        r_state   <= S_I_WAIT;
                    end
                end
                S_I_WAIT: begin
                    r_ih    <= rd;
                    r_state <= S_I_WALK;
                end
                S_I_MERGE: begin
                    // predecessor ends where this block starts: grow it
                    if (merge_c) begin
                        r_bh <= '{size: r_ih.size + r_bh.size, alloc: r_ih.alloc,
                                  nv: r_ih.nv, next: r_ih.next};
                        r_b  <= r_it;
                    end
                    r_state <= S_I_ADJ;
                end
                S_I_ADJ: begin
                    if (adj_c && r_nxt != cur_end) begin
                        r_state <= S_I_NWAIT;
                    end else begin
                        r_bh.nv   <= 1'b1;
                        r_bh.next <= adj_c ? cur_end : r_nxt;
                        r_state   <= S_I_WR;
                    end
                end
                S_I_NWAIT: begin
                    r_bh.size <= r_bh.size + rd.size;
                    r_bh.nv   <= rd.nv;
                    r_bh.next <= rd.next;
                    r_state   <= S_I_WR;
                end
                S_I_WR: begin
                    if (r_at_head) begin
                        r_head[r_p] <= r_b;
                        r_state     <= r_ret_alloc ? S_A_FIN : S_DONE;
                    end else if (r_it != r_b) begin
                        r_state <= S_I_LINK;
                    end else begin
                        r_state <= r_ret_alloc ? S_A_FIN : S_DONE;
                    end
                end
                S_I_LINK: begin
                    r_state <= r_ret_alloc ? S_A_FIN : S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status         = r_status;
        o_res.granted_offset = r_grant;
        if (r_bad) begin
            o_res.free_bytes     = '0;
            o_res.min_free_bytes = '0;
        end else begin
            o_res.free_bytes     = FREE_W'(r_fc[r_p]);
            o_res.min_free_bytes = FREE_W'(r_min[r_p]);
        end
    end

endmodule

>>> rtl/first_fit_coalescing_heap_allocator.sv
// ============================================================================
// first_fit_coalescing_heap_allocator - first-fit free-list heap allocator
// Sequence: alloc walks one free block per header read, unlinks the fit
//   and, on a split, reinserts the remainder; free checks the header and
//   reinserts the block with merging. The first request to a pool runs
//   setup first. One item at a time: the next word is taken once the
//   result has moved to the output register. The header RAM read (one
//   header per cycle, registered) sets the walk speed.
// Reset: pool state cleared, all pools uninitialized; the header RAM is not
//   cleared (each pool writes what it needs at setup). No clearing pass.
// ============================================================================
module first_fit_coalescing_heap_allocator import ffch_pkg::*; #(
    parameter int POOLS             = POOLS_DEF,
    parameter int MAX_POOL_GRANULES = MAX_GRAN_DEF,
    parameter int ALIGN_BYTES       = ALIGN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request words
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [0] opcode, [2:1] pool, [26:3] request_bytes, [42:27] payload_offset
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // result words
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [1:0] status, [17:2] granted_offset, [34:18] free_bytes,
    // [51:35] min_free_bytes
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int GW    = $clog2(MAX_POOL_GRANULES);
    localparam int HW    = 2 * GW + 2;           // size, alloc, next-valid, next
    localparam int DEPTH = POOLS * (1 << GW);    // one header slot per granule
    localparam int AW    = $clog2(DEPTH);

    // pool size registers, sampled by a pool only when it sets itself up
    logic [CFG_REGS-1:0][CFG_W-1:0] r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_cfg[i] <= CFG_RESET;
            end
        end else if (i_cfg_wr_en && i_cfg_addr < CFG_IDX_W'(CFG_REGS)) begin
            r_cfg[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // request side
    t_req w_req;
    logic w_s_accept;
    logic w_core_ready;

    assign w_req      = t_req'(i_s_tdata[REQ_BITS-1:0]);
    assign o_s_tready = w_core_ready;
    assign w_s_accept = i_s_tvalid & w_core_ready;

    // result register: the core finishes into it and moves on while the
    // word waits for the sink
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;
    logic w_res_load;
    logic r_m_valid;
    t_res r_m_res;

    assign w_res_ready = !r_m_valid || i_m_tready;
    assign w_res_load  = w_res_valid && w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = M_TDATA_W'(r_m_res);

    // header memory
    logic          w_mem_we, w_mem_re;
    logic [AW-1:0] w_mem_waddr, w_mem_raddr;
    logic [HW-1:0] w_mem_wdata, w_mem_rdata;

    ffch_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    ffch_core #(
        .POOLS             (POOLS),
        .MAX_POOL_GRANULES (MAX_POOL_GRANULES),
        .ALIGN_BYTES       (ALIGN_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_s_accept),
        .o_ready     (w_core_ready),
        .i_req       (w_req),
        .i_cfg_gran  (r_cfg[POOLS-1:0]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // a new request is never taken in the cycle a result is produced
    a_accept_vs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |-> !w_res_load)
        else $error("request accepted while a result is being produced");

    // only a successful allocate hands out an offset
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && w_res.status != ST_OK) |-> (w_res.granted_offset == '0))
        else $error("offset granted on a failed request");

    // bad pool reports no pool state
    a_bad_pool_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_load && w_res.status == ST_BAD_POOL)
        |-> (w_res.free_bytes == '0 && w_res.min_free_bytes == '0))
        else $error("bad pool result carries pool counters");

    // low-water mark never above the current free count
    a_min_le_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> (w_res.min_free_bytes <= w_res.free_bytes))
        else $error("min free bytes above free bytes");

endmodule
